/* rtl/core/spcs_pkg.sv */
// Package with shared types, code constants and phase pattern tables for the sequencer.
`timescale 1ns / 1ps

package spcs_pkg;

  // Number of axis slots that the fixed input fields can carry.
  localparam int MaxAxes = 3;

  // Item function codes.
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_LEVEL = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FULL_STEP_MASK = 2'd0;
  localparam logic [1:0] CFG_OFF_THRESHOLD  = 2'd1;
  localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd2;
  localparam logic [1:0] CFG_MID_THRESHOLD  = 2'd3;

  // Current level codes.
  typedef logic [1:0] level_t;
  localparam level_t LVL_OFF = 2'd0;
  localparam level_t LVL_20  = 2'd1;
  localparam level_t LVL_60  = 2'd2;
  localparam level_t LVL_MAX = 2'd3;

  // Threshold values after reset.
  localparam logic [7:0] OFF_THRESHOLD_RST = 8'd0;
  localparam logic [7:0] LOW_THRESHOLD_RST = 8'd51;
  localparam logic [7:0] MID_THRESHOLD_RST = 8'd153;

  // Half step patterns, by level code and by the whole phase index.
  localparam logic [5:0] HALF_TAB [4][8] = '{
    '{6'h3F, 6'h3F, 6'h1F, 6'h1F, 6'h1B, 6'h1B, 6'h3B, 6'h3B},
    '{6'h37, 6'h36, 6'h1E, 6'h16, 6'h13, 6'h12, 6'h3A, 6'h32},
    '{6'h2F, 6'h2D, 6'h1D, 6'h0D, 6'h0B, 6'h09, 6'h39, 6'h29},
    '{6'h27, 6'h2D, 6'h1C, 6'h0D, 6'h03, 6'h09, 6'h38, 6'h29}
  };

  // Full step patterns, by level code and by the low two bits of the phase index.
  localparam logic [5:0] FULL_TAB [4][4] = '{
    '{6'h3F, 6'h3B, 6'h1B, 6'h1F},
    '{6'h36, 6'h32, 6'h12, 6'h16},
    '{6'h2D, 6'h29, 6'h09, 6'h0D},
    '{6'h24, 6'h20, 6'h00, 6'h04}
  };

  // A batch of commands from one item: one slot per axis, in axis order.
  typedef struct packed {
    logic [MaxAxes-1:0]      mask;
    logic [MaxAxes-1:0][7:0] cmd;
  } spcs_batch_t;

  // Looks up the coil pattern for one axis.
  function automatic logic [5:0] phase_pattern(input logic full, input level_t lv,
                                               input logic [2:0] ph);
    logic [5:0] pat;
    if (full) begin
      pat = FULL_TAB[lv][ph[1:0]];
    end else begin
      pat = HALF_TAB[lv][ph];
    end
    return pat;
  endfunction

endpackage

/* rtl/core/spcs_core.sv */
// Input register, configuration registers, axis state and command byte generation.
`timescale 1ns / 1ps

module spcs_core #(
  parameter int AXIS_COUNT = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [7:0]          steps_x,
  input  logic [7:0]          steps_y,
  input  logic [7:0]          steps_z,
  input  logic [2:0]          dir_up_mask,
  input  logic [1:0]          target_axis,
  input  logic [7:0]          drive_level,
  input  logic                force_update,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                batch_free,
  output logic                batch_push,
  output spcs_pkg::spcs_batch_t batch
);

  // Registered copy of the accepted word.
  logic       iv;
  logic       r_func;
  logic [7:0] r_steps [spcs_pkg::MaxAxes];
  logic [2:0] r_dir;
  logic [1:0] r_target;
  logic [7:0] r_level;
  logic       r_force;

  // Configuration registers.
  logic [2:0] full_step_mask;
  logic [7:0] off_threshold;
  logic [7:0] low_threshold;
  logic [7:0] mid_threshold;

  // Per-axis state.
  logic [2:0]         phase [AXIS_COUNT];
  spcs_pkg::level_t   level [AXIS_COUNT];
  logic [2:0]         phase_next [AXIS_COUNT];
  spcs_pkg::level_t   level_next [AXIS_COUNT];

  spcs_pkg::level_t quant;
  logic             commit;
  logic             load;

  // Quantise the requested level, testing from the top threshold down.
  always_comb begin
    if (r_level > mid_threshold) begin
      quant = spcs_pkg::LVL_MAX;
    end else if (r_level > low_threshold) begin
      quant = spcs_pkg::LVL_60;
    end else if (r_level > off_threshold) begin
      quant = spcs_pkg::LVL_20;
    end else begin
      quant = spcs_pkg::LVL_OFF;
    end
  end

  // New axis state and the command byte of every axis that reports.
  always_comb begin
    batch = '0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      phase_next[a] = phase[a];
      level_next[a] = level[a];
      if (r_func == spcs_pkg::FUNC_STEP) begin
        if (r_steps[a] != 8'd0) begin
          if (r_dir[a]) begin
            phase_next[a] = phase[a] + r_steps[a][2:0];
          end else begin
            phase_next[a] = phase[a] - r_steps[a][2:0];
          end
          batch.mask[a] = 1'b1;
        end
      end else if (r_target == 2'(a)) begin
        level_next[a] = quant;
        batch.mask[a] = r_force;
      end
      batch.cmd[a] = {2'(a), spcs_pkg::phase_pattern(full_step_mask[a], level_next[a],
                                                     phase_next[a])};
    end
  end

  // An item with no command commits at once; others wait for a free batch slot.
  assign commit     = iv && ((batch.mask == '0) || batch_free);
  assign batch_push = commit && (batch.mask != '0);
  assign in_stall   = iv && !commit;
  assign load       = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (load) begin
      iv <= 1'b1;
    end else if (commit) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_func     <= func;
      r_steps[0] <= steps_x;
      r_steps[1] <= steps_y;
      r_steps[2] <= steps_z;
      r_dir      <= dir_up_mask;
      r_target   <= target_axis;
      r_level    <= drive_level;
      r_force    <= force_update;
    end
  end

  // Axis state advances when the item commits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        phase[a] <= 3'd0;
        level[a] <= spcs_pkg::LVL_OFF;
      end
    end else if (commit) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        phase[a] <= phase_next[a];
        level[a] <= level_next[a];
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_step_mask <= 3'd0;
      off_threshold  <= spcs_pkg::OFF_THRESHOLD_RST;
      low_threshold  <= spcs_pkg::LOW_THRESHOLD_RST;
      mid_threshold  <= spcs_pkg::MID_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        spcs_pkg::CFG_FULL_STEP_MASK: full_step_mask <= cfg_data[2:0];
        spcs_pkg::CFG_OFF_THRESHOLD:  off_threshold  <= cfg_data;
        spcs_pkg::CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        spcs_pkg::CFG_MID_THRESHOLD:  mid_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/spcs_emit.sv */
// Result register: holds one batch, hands out one word a cycle while out_stall is low.
`timescale 1ns / 1ps

module spcs_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  batch_push,
  input  spcs_pkg::spcs_batch_t batch,
  output logic                  batch_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            command_byte,
  output logic [1:0]            cmd_axis,
  output logic                  last
);

  logic [spcs_pkg::MaxAxes-1:0]      pend;
  logic [spcs_pkg::MaxAxes-1:0][7:0] cmd;
  logic [spcs_pkg::MaxAxes-1:0]      pend_rest;
  logic                              take;

  // Lowest pending slot goes first, so commands leave in axis order.
  always_comb begin
    cmd_axis = 2'd0;
    for (int a = spcs_pkg::MaxAxes - 1; a >= 0; a--) begin
      if (pend[a]) begin
        cmd_axis = 2'(a);
      end
    end
  end

  assign command_byte = cmd[cmd_axis];
  assign pend_rest    = pend & (pend - {{(spcs_pkg::MaxAxes-1){1'b0}}, 1'b1});
  assign last         = (pend_rest == '0);
  assign out_valid    = (pend != '0);
  assign take         = out_valid && !out_stall;
  assign batch_free   = !out_valid || (take && last);

  // Pending mask: loaded with a new batch, one slot cleared per word taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (batch_push) begin
      pend <= batch.mask;
    end else if (take) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_push) begin
      cmd <= batch.cmd;
    end
  end

endmodule

/* rtl/core/stepper_phase_command_sequencer_unit.sv */
// Top level of the three-axis stepper phase command sequencer.
// An item passes the input register, then the result register offers its command words.
// Throughput: one command word per cycle while out_stall is low; an item with k commands
// holds the result register until its k words are taken, k at most three.
// Reset: phase indexes and level codes clear to zero, thresholds take their defaults,
// and all pending words are dropped.
`timescale 1ns / 1ps

module stepper_phase_command_sequencer_unit #(
  parameter int AXIS_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] steps_x,
  input  logic [7:0] steps_y,
  input  logic [7:0] steps_z,
  input  logic [2:0] dir_up_mask,
  input  logic [1:0] target_axis,
  input  logic [7:0] drive_level,
  input  logic       force_update,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] command_byte,
  output logic [1:0] cmd_axis,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  spcs_pkg::spcs_batch_t batch;
  logic                  batch_push;
  logic                  batch_free;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  spcs_core #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .steps_x     (steps_x),
    .steps_y     (steps_y),
    .steps_z     (steps_z),
    .dir_up_mask (dir_up_mask),
    .target_axis (target_axis),
    .drive_level (drive_level),
    .force_update(force_update),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .batch_free  (batch_free),
    .batch_push  (batch_push),
    .batch       (batch)
  );

  spcs_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .batch_push  (batch_push),
    .batch       (batch),
    .batch_free  (batch_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .command_byte(command_byte),
    .cmd_axis    (cmd_axis),
    .last        (last)
  );

endmodule
